// ===== rtl/thrc_pkg.sv =====
// Shared widths, codes and types for the harmonic root classifier.
package thrc_pkg;

    localparam int IN_W   = 24;
    localparam int NSTG   = 8;
    localparam int GW     = 116;

    localparam logic [31:0] TAN_RESET  = 32'd42950960;
    localparam logic [47:0] TOL_RESET  = 48'd0;
    localparam logic        MODE_RESET = 1'b1;

    localparam logic [1:0] REG_TAN  = 2'd0;
    localparam logic [1:0] REG_TOL  = 2'd1;
    localparam logic [1:0] REG_MODE = 2'd2;

    localparam logic [1:0] CLS_GENERIC = 2'd0;
    localparam logic [1:0] CLS_SIMPLE  = 2'd1;
    localparam logic [1:0] CLS_DOUBLE  = 2'd2;

    typedef struct packed {
        logic neg_a;
        logic zero_a;
        logic neg_b;
        logic zero_b;
        logic neg_c;
        logic zero_c;
    } sign_flags_t;

endpackage

// ===== rtl/trig_harmonic_root_classifier.sv =====
// Harmonic root classifier: eight-stage pipeline from cross products to root decision.
// Throughput: one beat per cycle; each stage holds on a stall and frees when downstream moves.
// Depth comes from the exact wide math: products, sums, magnitudes, partials, sums, terms, g, verdict.
// Reset (aresetn low, synchronous) clears all stage valid bits and loads the register
// defaults; the block takes beats on the cycle after reset is released.
module trig_harmonic_root_classifier
    import thrc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // edge_cos_x, edge_cos_y, edge_sin_x, edge_sin_y,
    // wit_cos_x, wit_cos_y, wit_sin_x, wit_sin_y (24 bits each, from bit 0 up)
    input  logic [191:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // no_root [0], root_class [2:1], zero fill [7:3]
    output logic [7:0]   m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [47:0]  cfg_wdata
);

    // configuration
    logic [31:0] tan_reg;
    logic [47:0] tol_reg;
    logic        mode_reg;
    logic [63:0] tan_sq_reg;

    // pipeline control
    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] stg_ready;

    // stage 0: cross products
    logic signed [IN_W-1:0]   vin [8];
    logic signed [2*IN_W-1:0] prod_next [8];
    logic signed [2*IN_W-1:0] prod_reg  [8];

    // stage 1: C, A, B
    logic signed [48:0] c1_next, a1_next, c1_reg, a1_reg;
    logic signed [49:0] b1_next, b1_reg;

    // stage 2: magnitudes and signs
    logic [47:0]        mag_a2_next, mag_c2_next, mag_a2_reg, mag_c2_reg;
    logic [48:0]        mag_b2_next, mag_b2_reg;
    sign_flags_t        flg2_next, flg2_reg;
    logic signed [48:0] c2_reg;

    // stage 3: classification and partial products
    logic [24:0] bh;
    logic [23:0] bl, ah, al, ch, cl;
    logic [31:0] t2h, t2l;
    logic [1:0]  cls3_next, cls3_reg;
    logic [49:0] bb_hh_next, bb_hh_reg;
    logic [48:0] bb_hl_next, bb_hl_reg;
    logic [47:0] bb_ll_next, bb_ll_reg;
    logic [47:0] ac_hh_next, ac_hl_next, ac_lh_next, ac_ll_next;
    logic [47:0] ac_hh_reg, ac_hl_reg, ac_lh_reg, ac_ll_reg;
    logic [55:0] aht_next, alt_next, aht_reg, alt_reg;
    logic [56:0] bht_next, bht_reg;
    logic [55:0] blt_next, blt_reg;
    logic [55:0] at_hh_next, at_hl_next, at_lh_next, at_ll_next;
    logic [55:0] at_hh_reg, at_hl_reg, at_lh_reg, at_ll_reg;
    logic [48:0] mag_b3_reg;
    sign_flags_t flg3_reg;
    logic signed [48:0] c3_reg;

    // stage 4: product sums
    logic [97:0]  p1_next, p1_reg;
    logic [95:0]  p2_next, p2_reg;
    logic [79:0]  p3_next, p3_reg;
    logic [80:0]  bt_next, bt_reg;
    logic [111:0] at2_next, at2_reg;
    logic [48:0]  mag_b4_reg;
    logic [1:0]   cls4_reg;
    sign_flags_t  flg4_reg;
    logic signed [48:0] c4_reg;

    // stage 5: signed terms and magnitude compares
    logic signed [81:0]  term_b_next, term_b_reg;
    logic signed [112:0] term_a_next, term_a_reg;
    logic        opp_ab;
    logic        disc_next, in1_next, in2_next;
    logic        disc5_reg, in1_5_reg, in2_5_reg;
    logic [1:0]  cls5_reg;
    sign_flags_t flg5_reg;
    logic signed [48:0] c5_reg;

    // stage 6: g(T) scaled by 2^64
    logic signed [GW-1:0] g_next, g_reg;
    logic        disc6_reg, in1_6_reg, in2_6_reg;
    logic [1:0]  cls6_reg;
    sign_flags_t flg6_reg;

    // stage 7: result
    logic        g_neg, g_zero, c_g_same, a_c_same, nr_next;
    logic        nr_reg;
    logic [1:0]  cls7_reg;

    // ---------------------------------------------------------------- control
    always_comb begin
        stg_ready[NSTG-1] = !valid_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg_ready[k] = !valid_reg[k] || stg_ready[k+1];
        end
    end

    // hold the input off while reset is asserted
    assign s_tready = stg_ready[0] && aresetn;
    assign m_tvalid = valid_reg[NSTG-1];
    assign m_tdata  = {5'b0, cls7_reg, nr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stg_ready[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (stg_ready[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tan_reg  <= TAN_RESET;
            tol_reg  <= TOL_RESET;
            mode_reg <= MODE_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_TAN:  tan_reg  <= cfg_wdata[31:0];
                REG_TOL:  tol_reg  <= cfg_wdata;
                REG_MODE: mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // T^2 is registered from tan_reg and follows it in the cycle after a write
    always_ff @(posedge aclk) begin
        tan_sq_reg <= tan_reg * tan_reg;
    end

    // ---------------------------------------------------------------- stage 0
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            vin[i] = $signed(s_tdata[i*IN_W +: IN_W]);
        end
        prod_next[0] = vin[0] * vin[5];   // ecx*wcy
        prod_next[1] = vin[1] * vin[4];   // ecy*wcx
        prod_next[2] = vin[2] * vin[7];   // esx*wsy
        prod_next[3] = vin[3] * vin[6];   // esy*wsx
        prod_next[4] = vin[0] * vin[7];   // ecx*wsy
        prod_next[5] = vin[1] * vin[6];   // ecy*wsx
        prod_next[6] = vin[2] * vin[5];   // esx*wcy
        prod_next[7] = vin[3] * vin[4];   // esy*wcx
    end

    // ---------------------------------------------------------------- stage 1
    assign c1_next = 49'(prod_reg[0]) - 49'(prod_reg[1]);
    assign a1_next = 49'(prod_reg[2]) - 49'(prod_reg[3]);
    assign b1_next = (50'(prod_reg[4]) - 50'(prod_reg[5]))
                   + (50'(prod_reg[6]) - 50'(prod_reg[7]));

    // ---------------------------------------------------------------- stage 2
    always_comb begin
        mag_a2_next      = a1_reg[48] ? 48'(-a1_reg) : 48'(a1_reg);
        mag_c2_next      = c1_reg[48] ? 48'(-c1_reg) : 48'(c1_reg);
        mag_b2_next      = b1_reg[49] ? 49'(-b1_reg) : 49'(b1_reg);
        flg2_next.neg_a  = a1_reg[48];
        flg2_next.zero_a = (a1_reg == '0);
        flg2_next.neg_b  = b1_reg[49];
        flg2_next.zero_b = (b1_reg == '0);
        flg2_next.neg_c  = c1_reg[48];
        flg2_next.zero_c = (c1_reg == '0);
    end

    // ---------------------------------------------------------------- stage 3
    assign bh  = mag_b2_reg[48:24];
    assign bl  = mag_b2_reg[23:0];
    assign ah  = mag_a2_reg[47:24];
    assign al  = mag_a2_reg[23:0];
    assign ch  = mag_c2_reg[47:24];
    assign cl  = mag_c2_reg[23:0];
    assign t2h = tan_sq_reg[63:32];
    assign t2l = tan_sq_reg[31:0];

    always_comb begin
        if ({mag_c2_reg, 1'b0} > {1'b0, tol_reg}) begin
            cls3_next = CLS_GENERIC;
        end else if ({mag_b2_reg, 1'b0} > {2'b0, tol_reg}) begin
            cls3_next = CLS_SIMPLE;
        end else begin
            cls3_next = CLS_DOUBLE;
        end
    end

    assign bb_hh_next = bh * bh;
    assign bb_hl_next = bh * bl;
    assign bb_ll_next = bl * bl;
    assign ac_hh_next = ah * ch;
    assign ac_hl_next = ah * cl;
    assign ac_lh_next = al * ch;
    assign ac_ll_next = al * cl;
    assign aht_next   = ah * tan_reg;
    assign alt_next   = al * tan_reg;
    assign bht_next   = bh * tan_reg;
    assign blt_next   = bl * tan_reg;
    assign at_hh_next = ah * t2h;
    assign at_hl_next = ah * t2l;
    assign at_lh_next = al * t2h;
    assign at_ll_next = al * t2l;

    // ---------------------------------------------------------------- stage 4
    assign p1_next  = {bb_hh_reg, 48'b0} + 98'({bb_hl_reg, 25'b0}) + 98'(bb_ll_reg);
    assign p2_next  = {ac_hh_reg, 48'b0} + 96'({ac_hl_reg, 24'b0})
                    + 96'({ac_lh_reg, 24'b0}) + 96'(ac_ll_reg);
    assign p3_next  = {aht_reg, 24'b0} + 80'(alt_reg);
    assign bt_next  = {bht_reg, 24'b0} + 81'(blt_reg);
    assign at2_next = {at_hh_reg, 56'b0} + 112'({at_hl_reg, 24'b0})
                    + 112'({at_lh_reg, 32'b0}) + 112'(at_ll_reg);

    // ---------------------------------------------------------------- stage 5
    assign opp_ab = !flg4_reg.zero_a && !flg4_reg.zero_b
                 && (flg4_reg.neg_a != flg4_reg.neg_b);

    always_comb begin
        term_b_next = flg4_reg.neg_b ? -$signed({1'b0, bt_reg}) : $signed({1'b0, bt_reg});
        term_a_next = flg4_reg.neg_a ? -$signed({1'b0, at2_reg}) : $signed({1'b0, at2_reg});
        disc_next   = (p1_reg >= {p2_reg, 2'b00});
        // root of B + k*A*x inside (0,T), for k of one and two (k of two: the derivative)
        in1_next    = opp_ab && ({mag_b4_reg, 32'b0} < {1'b0, p3_reg});
        in2_next    = opp_ab && ({mag_b4_reg, 32'b0} < {p3_reg, 1'b0});
    end

    // ---------------------------------------------------------------- stage 6
    assign g_next = 116'($signed({c5_reg, 64'b0})) + 116'($signed({term_b_reg, 32'b0}))
                  + 116'(term_a_reg);

    // ---------------------------------------------------------------- stage 7
    always_comb begin
        g_neg    = g_reg[GW-1];
        g_zero   = (g_reg == '0);
        c_g_same = !flg6_reg.zero_c && !g_zero && (flg6_reg.neg_c == g_neg);
        a_c_same = !flg6_reg.zero_a && (flg6_reg.neg_a == flg6_reg.neg_c);
        case (cls6_reg)
            CLS_GENERIC: begin
                if (!c_g_same) begin
                    nr_next = 1'b0;
                end else begin
                    nr_next = !(a_c_same && disc6_reg && in2_6_reg);
                end
            end
            CLS_SIMPLE: nr_next = !in1_6_reg;
            CLS_DOUBLE: nr_next = mode_reg ? 1'b1 : !in1_6_reg;
            default:    nr_next = 1'b1;
        endcase
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge aclk) begin
        if (stg_ready[0]) begin
            for (int i = 0; i < 8; i++) begin
                prod_reg[i] <= prod_next[i];
            end
        end
        if (stg_ready[1]) begin
            c1_reg <= c1_next;
            a1_reg <= a1_next;
            b1_reg <= b1_next;
        end
        if (stg_ready[2]) begin
            mag_a2_reg <= mag_a2_next;
            mag_b2_reg <= mag_b2_next;
            mag_c2_reg <= mag_c2_next;
            flg2_reg   <= flg2_next;
            c2_reg     <= c1_reg;
        end
        if (stg_ready[3]) begin
            cls3_reg   <= cls3_next;
            bb_hh_reg  <= bb_hh_next;
            bb_hl_reg  <= bb_hl_next;
            bb_ll_reg  <= bb_ll_next;
            ac_hh_reg  <= ac_hh_next;
            ac_hl_reg  <= ac_hl_next;
            ac_lh_reg  <= ac_lh_next;
            ac_ll_reg  <= ac_ll_next;
            aht_reg    <= aht_next;
            alt_reg    <= alt_next;
            bht_reg    <= bht_next;
            blt_reg    <= blt_next;
            at_hh_reg  <= at_hh_next;
            at_hl_reg  <= at_hl_next;
            at_lh_reg  <= at_lh_next;
            at_ll_reg  <= at_ll_next;
            mag_b3_reg <= mag_b2_reg;
            flg3_reg   <= flg2_reg;
            c3_reg     <= c2_reg;
        end
        if (stg_ready[4]) begin
            p1_reg     <= p1_next;
            p2_reg     <= p2_next;
            p3_reg     <= p3_next;
            bt_reg     <= bt_next;
            at2_reg    <= at2_next;
            mag_b4_reg <= mag_b3_reg;
            cls4_reg   <= cls3_reg;
            flg4_reg   <= flg3_reg;
            c4_reg     <= c3_reg;
        end
        if (stg_ready[5]) begin
            term_b_reg <= term_b_next;
            term_a_reg <= term_a_next;
            disc5_reg  <= disc_next;
            in1_5_reg  <= in1_next;
            in2_5_reg  <= in2_next;
            cls5_reg   <= cls4_reg;
            flg5_reg   <= flg4_reg;
            c5_reg     <= c4_reg;
        end
        if (stg_ready[6]) begin
            g_reg     <= g_next;
            disc6_reg <= disc5_reg;
            in1_6_reg <= in1_5_reg;
            in2_6_reg <= in2_5_reg;
            cls6_reg  <= cls5_reg;
            flg6_reg  <= flg5_reg;
        end
        if (stg_ready[7]) begin
            nr_reg   <= nr_next;
            cls7_reg <= cls6_reg;
        end
    end

`ifndef SYNTH
    // any empty stage must let a new beat in
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(&valid_reg) |-> s_tready)
        else $error("input stalled with an empty pipeline stage");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !(m_tvalid && m_tready))
        |=> ($countones(valid_reg) == $past($countones(valid_reg)) + 1))
        else $error("accepted beat not tracked in pipeline");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (!(s_tvalid && s_tready) && m_tvalid && m_tready)
        |=> ($countones(valid_reg) + 1 == $past($countones(valid_reg))))
        else $error("delivered beat not retired from pipeline");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[3] && !stg_ready[4]) |=> valid_reg[3])
        else $error("stalled stage dropped its beat");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[2:1] == CLS_DOUBLE) && mode_reg) |-> m_tdata[0])
        else $error("double zero in three-class mode must report no root");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking stream testbench for the harmonic root classifier with a built-in verdict predictor.
`timescale 1ns / 1ps

module tb
    import thrc_pkg::*;
();

    localparam int FIELD_MIN = -8388608;
    localparam int FIELD_MAX = 8388607;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int EXP_DEPTH = 64;

    typedef logic signed [191:0] wide_t;

    // declared top-down so that edge_cos_x lands in bits 23:0
    typedef struct packed {
        logic signed [23:0] wsy, wsx, wcy, wcx, esy, esx, ecy, ecx;
    } harm_vec_t;

    typedef struct packed {
        logic [1:0] root_class;
        logic       no_root;
    } root_verdict_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic [191:0] s_tdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   m_tdata;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_addr = '0;
    logic [47:0]  cfg_wdata = '0;

    // mirror of the block's registers
    logic [31:0]  tan_cfg = TAN_RESET;
    logic [47:0]  tol_cfg = TOL_RESET;
    logic         mode_cfg = MODE_RESET;

    // expected verdicts in acceptance order
    root_verdict_t expected_fifo [EXP_DEPTH];
    int exp_wr_count = 0;
    int exp_rd_count = 0;
    int mismatch_count = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_cycles = 0;

    trig_harmonic_root_classifier u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ---------------- verdict predictor ----------------

    function automatic wide_t cross2(logic signed [23:0] ux, uy, vx, vy);
        wide_t x1, y1, x2, y2;
        x1 = 192'(ux);
        y1 = 192'(uy);
        x2 = 192'(vx);
        y2 = 192'(vy);
        return x1 * y2 - y1 * x2;
    endfunction

    function automatic wide_t mag_of(wide_t x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic int sign_of(wide_t x);
        if (x > 0) return 1;
        if (x < 0) return -1;
        return 0;
    endfunction

    // A*B < 0 and |B| < k*|A|*T, with T = t / 2^32
    function automatic logic root_inside(wide_t a, wide_t b, wide_t t, int k);
        if (sign_of(a) * sign_of(b) >= 0) return 1'b0;
        return (mag_of(b) <<< 32) < k * mag_of(a) * t;
    endfunction

    function automatic root_verdict_t predict_verdict(harm_vec_t v);
        wide_t a, b, c, t, tl, g;
        int sa, sc, sg;
        logic disc;
        root_verdict_t r;
        c = cross2(v.ecx, v.ecy, v.wcx, v.wcy);
        a = cross2(v.esx, v.esy, v.wsx, v.wsy);
        b = cross2(v.ecx, v.ecy, v.wsx, v.wsy) + cross2(v.esx, v.esy, v.wcx, v.wcy);
        t = 192'(tan_cfg);
        tl = 192'(tol_cfg);
        if (2 * mag_of(c) > tl) begin
            r.root_class = CLS_GENERIC;
        end else if (2 * mag_of(b) > tl) begin
            r.root_class = CLS_SIMPLE;
        end else begin
            r.root_class = CLS_DOUBLE;
        end
        case (r.root_class)
            CLS_GENERIC: begin
                // g(T) scaled by 2^64
                g = (c <<< 64) + ((b * t) <<< 32) + a * t * t;
                sa = sign_of(a);
                sc = sign_of(c);
                sg = sign_of(g);
                if (sc * sg <= 0) begin
                    r.no_root = 1'b0;
                end else begin
                    disc = (sa * sc <= 0) || (b * b >= 4 * mag_of(a) * mag_of(c));
                    r.no_root = !(disc && sa == sc && sa == sg && root_inside(a, b, t, 2));
                end
            end
            CLS_DOUBLE: begin
                r.no_root = mode_cfg ? 1'b1 : !root_inside(a, b, t, 1);
            end
            default: begin
                r.no_root = !root_inside(a, b, t, 1);
            end
        endcase
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic harm_vec_t vec_of(int ecx, ecy, esx, esy, wcx, wcy, wsx, wsy);
        harm_vec_t v;
        v.ecx = 24'(ecx);
        v.ecy = 24'(ecy);
        v.esx = 24'(esx);
        v.esy = 24'(esy);
        v.wcx = 24'(wcx);
        v.wcy = 24'(wcy);
        v.wsx = 24'(wsx);
        v.wsy = 24'(wsy);
        return v;
    endfunction

    function automatic logic signed [23:0] rand_field();
        logic signed [23:0] f;
        int k;
        case ($urandom_range(0, 3))
            0: f = 24'($urandom);
            1: begin
                k = $urandom_range(0, 30);
                f = 24'(k - 15);
            end
            2: begin
                k = $urandom_range(0, 8190);
                f = 24'(k - 4095);
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: f = 24'(FIELD_MIN);
                    1: f = 24'(FIELD_MAX);
                    2: f = '0;
                    default: f = '1;
                endcase
            end
        endcase
        return f;
    endfunction

    function automatic harm_vec_t random_vectors();
        harm_vec_t v;
        int k, m, aa, bb, cc;
        v.ecx = rand_field();
        v.ecy = rand_field();
        v.esx = rand_field();
        v.esy = rand_field();
        v.wcx = rand_field();
        v.wcy = rand_field();
        v.wsx = rand_field();
        v.wsy = rand_field();
        k = $urandom_range(0, 8);
        k = k - 4;
        case ($urandom_range(0, 9))
            4, 5: begin
                // witness cosine parallel to edge cosine: C is zero
                m = $urandom_range(0, 4094);
                v.ecx = 24'(m - 2047);
                m = $urandom_range(0, 4094);
                v.ecy = 24'(m - 2047);
                v.wcx = 24'(k * v.ecx);
                v.wcy = 24'(k * v.ecy);
            end
            6: begin
                // no edge cosine and edge sine parallel to witness cosine: C and B vanish
                m = $urandom_range(0, 4094);
                v.wcx = 24'(m - 2047);
                m = $urandom_range(0, 4094);
                v.wcy = 24'(m - 2047);
                v.ecx = '0;
                v.ecy = '0;
                v.esx = 24'(k * v.wcx);
                v.esy = 24'(k * v.wcy);
            end
            7, 8: begin
                // nearly parallel cosine parts: C small against B
                m = $urandom_range(0, 4094);
                v.ecx = 24'(m - 2047);
                m = $urandom_range(0, 4094);
                v.ecy = 24'(m - 2047);
                m = $urandom_range(0, 2);
                v.wcx = 24'(k * v.ecx + m - 1);
                m = $urandom_range(0, 2);
                v.wcy = 24'(k * v.ecy + m - 1);
            end
            9: begin
                // quadratic with C = cc, A = aa^2, B = bb, roots near the interval
                aa = $urandom_range(100, 2000);
                m = $urandom_range(0, 40);
                bb = -(aa * aa * m) / 1000;
                m = $urandom_range(0, 128);
                cc = m - 64;
                if ($urandom_range(0, 1)) begin
                    bb = -bb;
                end
                v = vec_of(1, 0, 0, -aa, 0, cc, aa, bb);
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [47:0] pick_tangent();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return 48'd0;
            1: return 48'hFFFF_FFFF;
            2: return 48'($urandom_range(0, 1 << 27));
            default: return r[47:0];
        endcase
    endfunction

    function automatic logic [47:0] pick_tolerance();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: return 48'd0;
            1: return 48'hFFFF_FFFF_FFFF;
            2: return 48'($urandom_range(0, 1 << 16));
            3: return 48'($urandom_range(0, 1 << 30));
            default: return r[47:0];
        endcase
    endfunction

    // ---------------- driving tasks (entered and left just after a falling edge) ----------------

    task automatic send_vectors(input harm_vec_t v);
        while ($urandom_range(0, 99) < tx_idle_pct) @(negedge aclk);
        s_tdata = v;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_fifo[6'(exp_wr_count)] = predict_verdict(v);
        exp_wr_count++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] data);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            REG_TAN:  tan_cfg = data[31:0];
            REG_TOL:  tol_cfg = data;
            REG_MODE: mode_cfg = data[0];
            default: ;
        endcase
    endtask

    task automatic wait_for_drain();
        while (exp_wr_count != exp_rd_count) @(negedge aclk);
        // let the pipeline settle past its latency
        repeat (12) @(negedge aclk);
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_defaults();
        send_vectors(vec_of(0, 0, 0, 0, 0, 0, 0, 0));
        send_vectors(vec_of(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX,
                            FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
        send_vectors(vec_of(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN,
                            FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN));
        send_vectors(vec_of(FIELD_MIN, FIELD_MIN, FIELD_MAX, FIELD_MIN,
                            FIELD_MAX, FIELD_MIN, FIELD_MIN, FIELD_MAX));
        send_vectors(vec_of(FIELD_MAX, FIELD_MIN, FIELD_MIN, FIELD_MAX,
                            FIELD_MIN, FIELD_MIN, FIELD_MAX, FIELD_MAX));
        // generic, sign change across the interval, then none
        send_vectors(vec_of(1, 0, 0, 0, 0, 1, 0, -1000));
        send_vectors(vec_of(1, 0, 0, 0, 0, 1, 0, 1000));
        // generic, two roots inside the interval, then none (negative discriminant)
        send_vectors(vec_of(1, 0, 0, -1000, 0, 24, 1000, -10000));
        send_vectors(vec_of(1, 0, 0, -1000, 0, 26, 1000, -10000));
        // simple zero, root inside and outside
        send_vectors(vec_of(0, 0, 1, 0, 0, -50, 0, 10000));
        send_vectors(vec_of(0, 0, 1, 0, 0, -200, 0, 10000));
        // double zero in three-class mode
        send_vectors(vec_of(0, 0, FIELD_MAX, FIELD_MIN, 0, 0, FIELD_MIN, FIELD_MAX));
    endtask

    task automatic test_register_extremes();
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        wait_for_drain();
        // upper bits beyond each register's width must be dropped
        write_reg(REG_TAN, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_TOL, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_MODE, 48'hABCD_0000_0000);
        write_reg(REG_UNUSED, junk[47:0]);
        // double zero under the two-class rule keeps the exact B
        send_vectors(vec_of(0, 0, 1, 0, 0, -50, 0, 10000));
        send_vectors(vec_of(FIELD_MIN, FIELD_MIN, FIELD_MAX, FIELD_MIN,
                            FIELD_MAX, FIELD_MIN, FIELD_MIN, FIELD_MAX));
        send_vectors(vec_of(FIELD_MAX, FIELD_MIN, FIELD_MIN, FIELD_MAX,
                            FIELD_MIN, FIELD_MIN, FIELD_MAX, FIELD_MAX));
        send_vectors(vec_of(1, 0, 0, -1000, 0, 24, 1000, -10000));
        wait_for_drain();
        // zero tangent, zero tolerance, three-class mode
        write_reg(REG_TAN, 48'd0);
        write_reg(REG_TOL, 48'd0);
        write_reg(REG_MODE, 48'hFFFF_FFFF_FFFF);
        send_vectors(vec_of(1, 0, 0, 0, 0, 1, 0, -1000));
        send_vectors(vec_of(0, 0, 1, 0, 0, -50, 0, 10000));
        send_vectors(vec_of(1, 0, 0, -1000, 0, 24, 1000, -10000));
        send_vectors(vec_of(FIELD_MIN, FIELD_MIN, FIELD_MAX, FIELD_MIN,
                            FIELD_MAX, FIELD_MIN, FIELD_MIN, FIELD_MAX));
    endtask

    task automatic test_random_phases();
        int tx_mix[4];
        int rx_mix[4];
        tx_mix = '{0, 81, 0, 15};
        rx_mix = '{0, 0, 81, 15};
        for (int p = 0; p < 4; p++) begin
            wait_for_drain();
            if (p == 0) begin
                write_reg(REG_TAN, 48'(TAN_RESET));
                write_reg(REG_TOL, 48'($urandom_range(0, 4096)));
            end else begin
                write_reg(REG_TAN, pick_tangent());
                write_reg(REG_TOL, pick_tolerance());
            end
            write_reg(REG_MODE, (p == 0 || p == 2) ? 48'd1 : 48'd0);
            tx_idle_pct = tx_mix[p];
            rx_stall_pct = rx_mix[p];
            repeat (170) send_vectors(random_vectors());
        end
    endtask

    task automatic test_backpressure();
        wait_for_drain();
        write_reg(REG_TAN, pick_tangent());
        write_reg(REG_TOL, 48'($urandom_range(0, 4096)));
        write_reg(REG_MODE, 48'd1);
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        // hold the result side off long enough for the pipeline to fill and stall its input
        rx_hold_cycles = 300;
        repeat (40) send_vectors(random_vectors());
    endtask

    task automatic test_drain_pause();
        tx_idle_pct = 15;
        rx_stall_pct = 40;
        repeat (15) send_vectors(random_vectors());
        while (exp_wr_count != exp_rd_count) @(negedge aclk);
        repeat (15) send_vectors(random_vectors());
    endtask

    // ---------------- result side ----------------

    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                m_tready = 1'b0;
                rx_hold_cycles--;
            end else begin
                m_tready = ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        root_verdict_t got;
        root_verdict_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = m_tdata[2:0];
                if (exp_wr_count == exp_rd_count) begin
                    mismatch_count++;
                    $display("%0t: unexpected result beat, expected none, actual %b",
                             $time, m_tdata);
                end else begin
                    want = expected_fifo[6'(exp_rd_count)];
                    exp_rd_count++;
                    if (got.no_root !== want.no_root) begin
                        mismatch_count++;
                        $display("%0t: no_root mismatch, expected %b actual %b",
                                 $time, want.no_root, got.no_root);
                    end
                    if (got.root_class !== want.root_class) begin
                        mismatch_count++;
                        $display("%0t: root_class mismatch, expected %0d actual %0d",
                                 $time, want.root_class, got.root_class);
                    end
                end
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_reset_defaults();
        test_register_extremes();
        test_random_phases();
        test_backpressure();
        test_drain_pause();
        wait_for_drain();
        if (exp_wr_count != exp_rd_count) begin
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/thrc_pkg.sv
rtl/trig_harmonic_root_classifier.sv
verif/tb.sv
